// File: hdl/etf_pkg.sv
// Shared types, constants and helpers for the escape-time fractal pixel core.
// No dependencies.
`timescale 1ns / 1ps

package etf_pkg;

    localparam int COORD_W = 10;
    localparam int FIX_W   = 64;
    localparam int PROD_W  = 128;
    localparam int CNT_W   = 20;
    localparam int IDX_W   = 3;

    localparam logic [1:0] MODE_MANDEL  = 2'd0;
    localparam logic [1:0] MODE_FIXED_C = 2'd1;
    localparam logic [1:0] MODE_DIST    = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_XSTART = 3'd1;
    localparam logic [IDX_W-1:0] REG_YSTART = 3'd2;
    localparam logic [IDX_W-1:0] REG_XSTEP  = 3'd3;
    localparam logic [IDX_W-1:0] REG_YSTEP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_JCRE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_JCIM   = 3'd6;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd7;

    localparam logic [FIX_W-1:0] DERIV_ONE = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               julia;
        logic               deriv;
    } t_job;

    typedef struct packed {
        logic [FIX_W-1:0] x_start;
        logic [FIX_W-1:0] y_start;
        logic [FIX_W-1:0] x_step;
        logic [FIX_W-1:0] y_step;
        logic [FIX_W-1:0] jc_re;
        logic [FIX_W-1:0] jc_im;
        logic [CNT_W-1:0] limit;
    } t_cfg;

    function automatic logic [FIX_W-1:0] sat129(input logic [PROD_W:0] v);
        logic [FIX_W-1:0] r;
        if (v[PROD_W:FIX_W-1] == {(PROD_W-FIX_W+2){v[PROD_W]}}) begin
            r = v[FIX_W-1:0];
        end else if (v[PROD_W]) begin
            r = {1'b1, {(FIX_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(FIX_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: hdl/escape_time_fractal_pixel_core.sv
// Top level of the escape-time fractal pixel core: configuration registers,
// front, job queue and iteration engine. Depends on etf_pkg, etf_front,
// etf_queue, etf_back.
//
// Usage: each input beat (i_valid, o_stall) names one pixel column and row;
// each output beat (o_valid, i_stall) returns that pixel's iteration count,
// final z (Q4.60) and, in distance mode, the derivative (Q32.32). Results come
// back in input order, one per pixel. Configuration is written on its own
// channel (i_cfg_valid, o_cfg_ready, always ready) by register index; the user
// must write it only while no pixel is in flight, as the block does not check.
// Forming the point takes two multiplies; every iteration squares both parts
// of z, tests for escape, in distance mode forms the four derivative products,
// then multiplies the real and imaginary parts and updates z, all on the one
// shared multiplier that retires one 32x32 partial product per cycle. A pixel
// runs N iterations, N up to the limit, and then goes to the output register.
// Up to three pixels wait in the front register and the two-entry queue.
// Synchronous reset clears all control state and the configuration
// (iteration limit 256, all else zero). When the receiver stalls, the result
// holds on the outputs; the engine finishes the next pixel and then waits.
`timescale 1ns / 1ps

module escape_time_fractal_pixel_core #(
    parameter int ESCAPE_RADIUS_SQUARED = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [etf_pkg::COORD_W-1:0]   i_pixel_col,
    input  logic [etf_pkg::COORD_W-1:0]   i_pixel_row,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [etf_pkg::COORD_W-1:0]   o_col_echo,
    output logic [etf_pkg::COORD_W-1:0]   o_row_echo,
    output logic [etf_pkg::CNT_W-1:0]     o_iter_count,
    output logic [etf_pkg::FIX_W-1:0]     o_final_z_real,
    output logic [etf_pkg::FIX_W-1:0]     o_final_z_imag,
    output logic [etf_pkg::FIX_W-1:0]     o_deriv_real,
    output logic [etf_pkg::FIX_W-1:0]     o_deriv_imag,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [etf_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [etf_pkg::FIX_W-1:0]     i_cfg_data
);
    logic [1:0]     r_mode;
    etf_pkg::t_cfg  r_cfg;
    logic           w_push, w_qfull, w_qvalid, w_pop;
    etf_pkg::t_job  w_fjob, w_qjob;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= etf_pkg::MODE_MANDEL;
            r_cfg.x_start <= '0;
            r_cfg.y_start <= '0;
            r_cfg.x_step  <= '0;
            r_cfg.y_step  <= '0;
            r_cfg.jc_re   <= '0;
            r_cfg.jc_im   <= '0;
            r_cfg.limit   <= 20'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                etf_pkg::REG_MODE:   r_mode        <= i_cfg_data[1:0];
                etf_pkg::REG_XSTART: r_cfg.x_start <= i_cfg_data;
                etf_pkg::REG_YSTART: r_cfg.y_start <= i_cfg_data;
                etf_pkg::REG_XSTEP:  r_cfg.x_step  <= i_cfg_data;
                etf_pkg::REG_YSTEP:  r_cfg.y_step  <= i_cfg_data;
                etf_pkg::REG_JCRE:   r_cfg.jc_re   <= i_cfg_data;
                etf_pkg::REG_JCIM:   r_cfg.jc_im   <= i_cfg_data;
                etf_pkg::REG_LIMIT:  r_cfg.limit   <= i_cfg_data[etf_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    etf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .i_mode      (r_mode),
        .i_q_full    (w_qfull),
        .o_push      (w_push),
        .o_job       (w_fjob)
    );

    etf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_qfull),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_qjob)
    );

    etf_back #(
        .ESC_R2 (ESCAPE_RADIUS_SQUARED)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_qvalid),
        .i_job          (w_qjob),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_col_echo     (o_col_echo),
        .o_row_echo     (o_row_echo),
        .o_iter_count   (o_iter_count),
        .o_final_z_real (o_final_z_real),
        .o_final_z_imag (o_final_z_imag),
        .o_deriv_real   (o_deriv_real),
        .o_deriv_imag   (o_deriv_imag)
    );
endmodule

// File: hdl/etf_mul.sv
// Iterative signed 64x64 multiplier, one 32x32 partial product per cycle.
// Depends on etf_pkg.
`timescale 1ns / 1ps

module etf_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [etf_pkg::FIX_W-1:0]    i_a,
    input  logic [etf_pkg::FIX_W-1:0]    i_b,
    output logic                         o_done,
    output logic [etf_pkg::PROD_W-1:0]   o_prod
);
    logic                          r_busy;
    logic [2:0]                    r_step;
    logic                          r_sign;
    logic [etf_pkg::FIX_W-1:0]     r_amag;
    logic [etf_pkg::FIX_W-1:0]     r_bmag;
    logic [etf_pkg::PROD_W-1:0]    r_acc;
    logic                          r_done;
    logic [etf_pkg::PROD_W-1:0]    r_prod;
    logic [31:0]                   w_asel;
    logic [31:0]                   w_bsel;
    logic [63:0]                   w_part;
    logic [etf_pkg::PROD_W-1:0]    w_shift;

    always_comb begin
        w_asel = r_step[1] ? r_amag[63:32] : r_amag[31:0];
        w_bsel = r_step[0] ? r_bmag[63:32] : r_bmag[31:0];
        w_part = w_asel * w_bsel;
        unique case (r_step[1:0])
            2'b00:   w_shift = {64'd0, w_part};
            2'b11:   w_shift = {w_part, 64'd0};
            default: w_shift = {32'd0, w_part, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_sign <= i_a[63] ^ i_b[63];
                r_amag <= i_a[63] ? (~i_a + 64'd1) : i_a;
                r_bmag <= i_b[63] ? (~i_b + 64'd1) : i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_prod <= r_sign ? (~r_acc + 128'd1) : r_acc;
                end else begin
                    r_acc  <= r_acc + w_shift;
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

// File: hdl/etf_front.sv
// Input side: holding register that takes pixel beats and tags the fractal mode.
// Depends on etf_pkg.
`timescale 1ns / 1ps

module etf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [etf_pkg::COORD_W-1:0]   i_pixel_col,
    input  logic [etf_pkg::COORD_W-1:0]   i_pixel_row,
    input  logic [1:0]                    i_mode,
    input  logic                          i_q_full,
    output logic                          o_push,
    output etf_pkg::t_job                 o_job
);
    logic          r_full;
    etf_pkg::t_job r_job;
    logic          w_acc;

    assign o_stall = r_full && i_q_full;
    assign w_acc   = i_valid && !o_stall;
    assign o_push  = r_full && !i_q_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (w_acc) begin
            r_full <= 1'b1;
        end else if (o_push) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_job.col   <= i_pixel_col;
            r_job.row   <= i_pixel_row;
            r_job.julia <= (i_mode == etf_pkg::MODE_FIXED_C);
            r_job.deriv <= (i_mode == etf_pkg::MODE_DIST);
        end
    end
endmodule

// File: hdl/etf_queue.sv
// Two-entry job queue between the front and the iteration engine.
// Depends on etf_pkg.
`timescale 1ns / 1ps

module etf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  etf_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output etf_pkg::t_job  o_job
);
    etf_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// File: hdl/etf_back.sv
// Iteration engine: pixel point, z and derivative loop on one shared multiplier,
// plus the result register. Depends on etf_pkg and etf_mul.
`timescale 1ns / 1ps

module etf_back #(
    parameter int ESC_R2 = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  etf_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_valid,
    input  etf_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [etf_pkg::COORD_W-1:0]   o_col_echo,
    output logic [etf_pkg::COORD_W-1:0]   o_row_echo,
    output logic [etf_pkg::CNT_W-1:0]     o_iter_count,
    output logic [etf_pkg::FIX_W-1:0]     o_final_z_real,
    output logic [etf_pkg::FIX_W-1:0]     o_final_z_imag,
    output logic [etf_pkg::FIX_W-1:0]     o_deriv_real,
    output logic [etf_pkg::FIX_W-1:0]     o_deriv_imag
);
    localparam int W  = etf_pkg::FIX_W;
    localparam int PW = etf_pkg::PROD_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PX   = 4'd1;
    localparam logic [3:0] S_PY   = 4'd2;
    localparam logic [3:0] S_INIT = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_ZR2  = 4'd5;
    localparam logic [3:0] S_ZI2  = 4'd6;
    localparam logic [3:0] S_ESC  = 4'd7;
    localparam logic [3:0] S_D1   = 4'd8;
    localparam logic [3:0] S_D2   = 4'd9;
    localparam logic [3:0] S_D3   = 4'd10;
    localparam logic [3:0] S_D4   = 4'd11;
    localparam logic [3:0] S_ZRI  = 4'd12;
    localparam logic [3:0] S_UPD  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    localparam logic [PW:0] THR = (PW+1)'(ESC_R2) << 120;

    logic [3:0]               r_state;
    logic                     r_mwait;
    etf_pkg::t_job            r_job;
    logic [W-1:0]             r_zr, r_zi, r_cr, r_ci, r_dr, r_di;
    logic [etf_pkg::CNT_W-1:0] r_cnt;
    logic [PW-1:0]            r_pr, r_pi, r_p1, r_p2, r_p3, r_p4, r_pz;

    logic                     r_ov;
    logic [etf_pkg::COORD_W-1:0] r_ocol, r_orow;
    logic [etf_pkg::CNT_W-1:0] r_ocnt;
    logic [W-1:0]             r_ozr, r_ozi, r_odr, r_odi;

    logic                     w_mstart, w_mdone, w_is_mul, w_ofree;
    logic [W-1:0]             w_ma, w_mb;
    logic [PW-1:0]            w_prod;
    logic [PW:0]              w_sum0;
    logic [W-1:0]             w_nr, w_ni, w_ndr, w_ndi, w_sat0;

    etf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    always_comb begin
        w_is_mul = 1'b1;
        unique case (r_state)
            S_PX: begin
                w_ma = {{(W-etf_pkg::COORD_W){1'b0}}, r_job.col};
                w_mb = i_cfg.x_step;
            end
            S_PY: begin
                w_ma = {{(W-etf_pkg::COORD_W){1'b0}}, r_job.row};
                w_mb = i_cfg.y_step;
            end
            S_ZR2: begin w_ma = r_zr; w_mb = r_zr; end
            S_ZI2: begin w_ma = r_zi; w_mb = r_zi; end
            S_D1:  begin w_ma = r_zr; w_mb = r_dr; end
            S_D2:  begin w_ma = r_zi; w_mb = r_di; end
            S_D3:  begin w_ma = r_zr; w_mb = r_di; end
            S_D4:  begin w_ma = r_zi; w_mb = r_dr; end
            S_ZRI: begin w_ma = r_zr; w_mb = r_zi; end
            default: begin
                w_ma = r_zr;
                w_mb = r_zi;
                w_is_mul = 1'b0;
            end
        endcase
    end

    assign w_mstart = w_is_mul && !r_mwait;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign w_ofree  = !r_ov || !i_stall;

    // pixel coordinate: start + index * step
    always_comb begin
        logic [W-1:0] base;
        base   = (r_state == S_PX) ? i_cfg.x_start : i_cfg.y_start;
        w_sum0 = {{(PW-W+1){base[W-1]}}, base} + {w_prod[PW-1], w_prod};
        w_sat0 = etf_pkg::sat129(w_sum0);
    end

    always_comb begin
        logic [PW:0] dz, dd, sd, pz;
        dz    = {r_pr[PW-1], r_pr} - {r_pi[PW-1], r_pi};
        dz    = $signed(dz) >>> 60;
        w_nr  = etf_pkg::sat129(dz + {{(PW-W+1){r_cr[W-1]}}, r_cr});
        pz    = $signed({r_pz[PW-1], r_pz}) >>> 59;
        w_ni  = etf_pkg::sat129(pz + {{(PW-W+1){r_ci[W-1]}}, r_ci});
        dd    = {r_p1[PW-1], r_p1} - {r_p2[PW-1], r_p2};
        dd    = $signed(dd) >>> 59;
        w_ndr = etf_pkg::sat129(dd + {{(PW-W+1){1'b0}}, etf_pkg::DERIV_ONE});
        sd    = {r_p3[PW-1], r_p3} + {r_p4[PW-1], r_p4};
        w_ndi = etf_pkg::sat129($signed(sd) >>> 59);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mwait <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_mstart) begin
                r_mwait <= 1'b1;
            end else if (w_mdone) begin
                r_mwait <= 1'b0;
            end
            if (r_state == S_DONE && w_ofree) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job   <= i_job;
                        r_state <= S_PX;
                    end
                end
                S_PX: if (w_mdone) begin
                    r_zr    <= w_sat0;
                    r_state <= S_PY;
                end
                S_PY: if (w_mdone) begin
                    r_zi    <= w_sat0;
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_cr    <= r_job.julia ? i_cfg.jc_re : r_zr;
                    r_ci    <= r_job.julia ? i_cfg.jc_im : r_zi;
                    r_dr    <= etf_pkg::DERIV_ONE;
                    r_di    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= (r_cnt >= i_cfg.limit) ? S_DONE : S_ZR2;
                end
                S_ZR2: if (w_mdone) begin
                    r_pr    <= w_prod;
                    r_state <= S_ZI2;
                end
                S_ZI2: if (w_mdone) begin
                    r_pi    <= w_prod;
                    r_state <= S_ESC;
                end
                S_ESC: begin
                    if (({1'b0, r_pr} + {1'b0, r_pi}) >= THR) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= r_job.deriv ? S_D1 : S_ZRI;
                    end
                end
                S_D1: if (w_mdone) begin
                    r_p1    <= w_prod;
                    r_state <= S_D2;
                end
                S_D2: if (w_mdone) begin
                    r_p2    <= w_prod;
                    r_state <= S_D3;
                end
                S_D3: if (w_mdone) begin
                    r_p3    <= w_prod;
                    r_state <= S_D4;
                end
                S_D4: if (w_mdone) begin
                    r_p4    <= w_prod;
                    r_state <= S_ZRI;
                end
                S_ZRI: if (w_mdone) begin
                    r_pz    <= w_prod;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_zr <= w_nr;
                    r_zi <= w_ni;
                    if (r_job.deriv) begin
                        r_dr <= w_ndr;
                        r_di <= w_ndi;
                    end
                    if (w_nr == '0 && w_ni == '0) begin
                        r_cnt   <= i_cfg.limit;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 20'd1;
                        r_state <= S_CHK;
                    end
                end
                S_DONE: begin
                    if (w_ofree) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_ofree) begin
            r_ocol <= r_job.col;
            r_orow <= r_job.row;
            r_ocnt <= r_cnt;
            r_ozr  <= r_zr;
            r_ozi  <= r_zi;
            r_odr  <= r_job.deriv ? r_dr : '0;
            r_odi  <= r_job.deriv ? r_di : '0;
        end
    end

    assign o_valid        = r_ov;
    assign o_col_echo     = r_ocol;
    assign o_row_echo     = r_orow;
    assign o_iter_count   = r_ocnt;
    assign o_final_z_real = r_ozr;
    assign o_final_z_imag = r_ozi;
    assign o_deriv_real   = r_odr;
    assign o_deriv_imag   = r_odi;
endmodule

// File: hdl/etf_chk.sv
// Port-level checker for the escape-time fractal pixel core, with its bind.
// Depends on escape_time_fractal_pixel_core.
`timescale 1ns / 1ps

module etf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [9:0]  o_col_echo,
    input logic [9:0]  o_row_echo,
    input logic [19:0] o_iter_count,
    input logic [63:0] o_final_z_real,
    input logic [63:0] o_final_z_imag
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_col_echo, o_row_echo, o_iter_count,
                                        o_final_z_real, o_final_z_imag}))
        else $error("stalled result changed");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");
endmodule

bind escape_time_fractal_pixel_core etf_chk u_etf_chk (.*);
